// ===== design/tsrw_pkg.sv =====
// shared types and constants for the tcp stream reassembly window
`default_nettype none
package tsrw_pkg;
  localparam int WINDOW_BYTES = 4096;
  localparam int OFF_W        = $clog2(WINDOW_BYTES);
  localparam int LEN_W        = 13;
  localparam int ADDR_W       = OFF_W + 1;
  localparam int ENTRY_W      = 9;
  localparam int GAP_W        = 16;

  localparam logic [LEN_W-1:0] CAP_MAX   = LEN_W'(WINDOW_BYTES);
  localparam logic [LEN_W-1:0] CAP_RESET = 13'd4096;
  localparam logic [GAP_W-1:0] GAP_RESET = 16'd2048;

  localparam logic [1:0] CMD_SEGMENT = 2'd0;
  localparam logic [1:0] CMD_CONSUME = 2'd1;
  localparam logic [1:0] CMD_LIMIT   = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic REG_WINDOW_CAP = 1'b0;
  localparam logic REG_GAP_LIMIT  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic        direction;
    logic [31:0] segment_seq;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] amount;
    logic        reset_matcher;
  } item_t;

  typedef struct packed {
    logic             status;
    logic             feed_valid;
    logic [LEN_W-1:0] feed_start;
    logic [LEN_W-1:0] feed_end;
    logic             restart_matcher;
    logic [LEN_W-1:0] contiguous_len;
    logic [7:0]       read_data;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0] cap;
    logic [GAP_W-1:0] gap_limit;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== design/tsrw_buf.sv =====
// byte buffer with received flag, both directions, one port, registered read
`default_nettype none
module tsrw_buf
  import tsrw_pkg::*;
(
  input  wire logic               clk,
  input  wire mem_req_t           req,
  output logic      [ENTRY_W-1:0] rdata
);
  logic [ENTRY_W-1:0] mem [2*WINDOW_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

// ===== design/tsrw_regs.sv =====
// apb configuration registers
`default_nettype none
module tsrw_regs
  import tsrw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);
  logic [LEN_W-1:0] window_cap;
  logic [GAP_W-1:0] gap_limit;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_cap <= CAP_RESET;
      gap_limit  <= GAP_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_WINDOW_CAP: window_cap <= pwdata[LEN_W-1:0];
        REG_GAP_LIMIT:  gap_limit  <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_CAP: prdata = {{(32-LEN_W){1'b0}}, window_cap};
      REG_GAP_LIMIT:  prdata = {{(32-GAP_W){1'b0}}, gap_limit};
      default:        prdata = '0;
    endcase
  end

  // zero or oversize cap means the full window
  assign cfg.cap = (window_cap == '0 || window_cap > CAP_MAX) ? CAP_MAX : window_cap;
  assign cfg.gap_limit = gap_limit;
endmodule
`default_nettype wire

// ===== design/tsrw_ctrl.sv =====
// command sequencer: per-direction pointers and buffer read-modify-write
`default_nettype none
module tsrw_ctrl
  import tsrw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire item_t              item,
  output logic                    busy,
  output logic                    done,
  output result_t                 result,
  input  wire cfg_t               cfg,
  output mem_req_t                mem_req,
  input  wire logic [ENTRY_W-1:0] mem_rdata
);
  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_SEG0 = 5'd2;
  localparam logic [4:0] ST_SEG1 = 5'd3;
  localparam logic [4:0] ST_SEG2 = 5'd4;
  localparam logic [4:0] ST_WRD  = 5'd5;
  localparam logic [4:0] ST_WCK  = 5'd6;
  localparam logic [4:0] ST_FEED = 5'd7;
  localparam logic [4:0] ST_CON0 = 5'd8;
  localparam logic [4:0] ST_CPRD = 5'd9;
  localparam logic [4:0] ST_CPWR = 5'd10;
  localparam logic [4:0] ST_CLRH = 5'd11;
  localparam logic [4:0] ST_CONF = 5'd12;
  localparam logic [4:0] ST_CONR = 5'd13;
  localparam logic [4:0] ST_LIM  = 5'd14;
  localparam logic [4:0] ST_RD0  = 5'd15;
  localparam logic [4:0] ST_RD1  = 5'd16;
  localparam logic [4:0] ST_DONE = 5'd17;

  logic [4:0]        state;
  logic [ADDR_W-1:0] clr_cnt;
  item_t             it;
  result_t           res;
  logic              d;

  logic [31:0]      seq_base [2];
  logic             base_known [2];
  logic [LEN_W-1:0] ce [2];
  logic [LEN_W-1:0] he [2];
  logic [LEN_W-1:0] sm [2];
  logic [LEN_W-1:0] bud [2];
  logic             failed;

  logic signed [31:0] soff;
  logic        [32:0] off;
  logic               in_win;
  logic [LEN_W-1:0]   n;
  logic [LEN_W-1:0]   keep;
  logic [LEN_W-1:0]   o;

  logic [32:0]      off_c;
  logic             in_win_c;
  logic [31:0]      soff_cl;
  logic [LEN_W-1:0] lim_c;
  logic [LEN_W-1:0] bud_eff;
  logic [LEN_W-1:0] feed_to;
  logic [LEN_W-1:0] n_c;
  logic [LEN_W-1:0] src;

  assign d        = it.direction;
  assign off_c    = {soff[31], soff} + {17'b0, it.byte_index};
  assign in_win_c = !off_c[32] && (off_c[31:0] < {{(32-LEN_W){1'b0}}, cfg.cap});
  assign soff_cl  = soff[31] ? 32'd0 : soff;
  assign lim_c    = (it.amount > {3'b0, cfg.cap}) ? cfg.cap : it.amount[LEN_W-1:0];
  assign bud_eff  = (state == ST_LIM) ? lim_c : bud[d];
  assign feed_to  = (ce[d] < bud_eff) ? ce[d] : bud_eff;
  assign n_c      = (it.amount > {3'b0, ce[d]}) ? ce[d] : it.amount[LEN_W-1:0];
  assign src      = o + n;

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = {d, o[OFF_W-1:0]};
    mem_req.wdata = '0;
    unique case (state)
      ST_CLR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_cnt;
      end
      ST_SEG1: mem_req.addr = {d, off_c[OFF_W-1:0]};
      ST_SEG2: begin
        mem_req.addr  = {d, off[OFF_W-1:0]};
        mem_req.we    = in_win && !mem_rdata[8];
        mem_req.wdata = {1'b1, it.data_byte};
      end
      ST_WRD:  mem_req.addr = {d, ce[d][OFF_W-1:0]};
      ST_CPRD: mem_req.addr = {d, src[OFF_W-1:0]};
      ST_CPWR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
      end
      ST_CLRH: mem_req.we = (o < he[d]);
      ST_RD0:  mem_req.addr = {d, it.amount[OFF_W-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_cnt <= '0;
      failed  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        seq_base[i]   <= '0;
        base_known[i] <= 1'b0;
        ce[i]         <= '0;
        he[i]         <= '0;
        sm[i]         <= '0;
        bud[i]        <= CAP_RESET;
      end
    end else begin
      unique case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            it  <= item;
            res <= '0;
            unique case (item.command)
              CMD_SEGMENT: state <= ST_SEG0;
              CMD_CONSUME: state <= ST_CON0;
              CMD_LIMIT:   state <= ST_LIM;
              CMD_READ:    state <= ST_RD0;
              default:     state <= ST_DONE;
            endcase
          end
        end
        ST_SEG0: begin
          if (failed) begin
            state <= ST_DONE;
          end else begin
            if (!base_known[d]) begin
              seq_base[d]   <= it.segment_seq;
              base_known[d] <= 1'b1;
            end
            soff  <= it.segment_seq - (base_known[d] ? seq_base[d] : it.segment_seq);
            state <= ST_SEG1;
          end
        end
        ST_SEG1: begin
          off    <= off_c;
          in_win <= in_win_c;
          state  <= ST_SEG2;
        end
        ST_SEG2: begin
          if (in_win && he[d] < off[LEN_W-1:0] + 1'b1) he[d] <= off[LEN_W-1:0] + 1'b1;
          if (!it.last_byte || off[32]) begin
            state <= ST_DONE;
          end else if (soff_cl >= {{(32-LEN_W){1'b0}}, cfg.cap}) begin
            // segment starts beyond the window: only the gap check applies
            if (ce[d] < cfg.cap &&
                ({1'b0, soff_cl} - {20'b0, ce[d]}) > {17'b0, cfg.gap_limit})
              failed <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_WRD;
          end
        end
        ST_WRD: state <= (ce[d] < cfg.cap) ? ST_WCK : ST_FEED;
        ST_WCK: begin
          if (mem_rdata[8]) begin
            ce[d] <= ce[d] + 1'b1;
            state <= ST_WRD;
          end else begin
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          if (feed_to > sm[d]) begin
            res.feed_valid <= 1'b1;
            res.feed_start <= sm[d];
            res.feed_end   <= feed_to;
            sm[d]          <= feed_to;
          end
          if (ce[d] < cfg.cap && he[d] > ce[d] &&
              {3'b0, he[d] - ce[d]} > cfg.gap_limit)
            failed <= 1'b1;
          state <= ST_DONE;
        end
        ST_LIM: begin
          bud[d] <= lim_c;
          if (feed_to > sm[d]) begin
            res.feed_valid <= 1'b1;
            res.feed_start <= sm[d];
            res.feed_end   <= feed_to;
            sm[d]          <= feed_to;
          end
          state <= ST_DONE;
        end
        ST_CON0: begin
          n     <= n_c;
          keep  <= (he[d] > n_c) ? he[d] - n_c : '0;
          o     <= '0;
          state <= (n_c == '0) ? ST_CONR : ST_CPRD;
        end
        ST_CPRD: state <= (o < keep) ? ST_CPWR : ST_CLRH;
        ST_CPWR: begin
          o     <= o + 1'b1;
          state <= ST_CPRD;
        end
        ST_CLRH: begin
          if (o < he[d]) o <= o + 1'b1;
          else state <= ST_CONF;
        end
        ST_CONF: begin
          seq_base[d] <= seq_base[d] + {19'b0, n};
          ce[d]       <= ce[d] - n;
          he[d]       <= keep;
          sm[d]       <= (sm[d] > n) ? sm[d] - n : '0;
          bud[d]      <= (bud[d] > n) ? bud[d] - n : '0;
          state       <= ST_CONR;
        end
        ST_CONR: begin
          if (it.reset_matcher) begin
            res.restart_matcher <= 1'b1;
            // the whole contiguous range is handed over again
            sm[d]  <= ce[d];
            bud[d] <= cfg.cap;
            if (ce[d] != '0) begin
              res.feed_valid <= 1'b1;
              res.feed_start <= '0;
              res.feed_end   <= ce[d];
            end
          end
          state <= ST_DONE;
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          if (it.amount < {3'b0, cfg.cap} && mem_rdata[8])
            res.read_data <= mem_rdata[7:0];
          state <= ST_DONE;
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  always_comb begin
    result                = res;
    result.status         = failed;
    result.contiguous_len = ce[d];
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside of a busy period");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");
  a_idle_nowrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_req.we)
    else $error("buffer written while idle");
  a_feed_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.feed_valid) |-> (result.feed_start < result.feed_end))
    else $error("empty or inverted feed range");
endmodule
`default_nettype wire

// ===== design/tcp_stream_reassembly_window.sv =====
// top level of the two-direction tcp reassembly window
`default_nettype none
// Two-direction TCP byte reassembly in a fixed window with a matcher feed.
// Items are taken with start while busy is low; each item yields exactly one
// result on the result port, marked by done for one cycle, and the receiver
// cannot stall it. All window bytes and their received flags live in a single
// one-port buffer memory with a registered read, so items are processed
// one at a time. A segment byte on a failed flow skips the buffer; a last
// byte that starts inside the window scans the buffer one contiguous byte
// at a time, and a consume copies each kept byte down and clears the rest
// up to the highest end before the pointers move.
// After reset the block sweeps the buffer clear with busy high;
// configuration writes are taken meanwhile.
module tcp_stream_reassembly_window
  import tsrw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // item side
  input  wire logic        start,
  input  wire item_t       item,
  output logic             busy,
  // result side
  output logic             done,
  output result_t          result,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  cfg_t               cfg;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  // register file: window cap and gap limit
  tsrw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte buffer, entry = {received, byte}, addressed by {direction, offset}
  tsrw_buf u_buf (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // sequencer holding per-direction pointers and the fail-closed flag
  tsrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the tcp stream reassembly window
`default_nettype none
module testbench;
  import tsrw_pkg::*;

  localparam int RUN_LIMIT = 60000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  item_t       item = '0;
  logic        busy;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tcp_stream_reassembly_window DUT (
    .clk(clk), .rst(rst),
    .start(start), .item(item), .busy(busy),
    .done(done), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mirror of the reassembly state, one copy per direction
  logic [7:0]  win_data [2][WINDOW_BYTES];
  bit          win_got  [2][WINDOW_BYTES];
  logic [31:0] seq_base [2];
  bit          base_set [2];
  int          contig   [2];
  int          high_end [2];
  int          scanned  [2];
  int          budget   [2];
  bit          fail_closed;
  int          cap_reg = 4096;
  int          gap_reg = 2048;

  result_t     expected_results [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          items_sent = 0;

  initial begin
    budget[0] = 4096;
    budget[1] = 4096;
  end

  function automatic int cap_now();
    return (cap_reg == 0 || cap_reg > WINDOW_BYTES) ? WINDOW_BYTES : cap_reg;
  endfunction

  // hand the newly contiguous range up to the budget to the matcher
  function automatic void feed_range(int d, ref result_t r);
    int upto;
    upto = contig[d] < budget[d] ? contig[d] : budget[d];
    if (upto > scanned[d]) begin
      r.feed_valid = 1'b1;
      r.feed_start = LEN_W'(scanned[d]);
      r.feed_end   = LEN_W'(upto);
      scanned[d]   = upto;
    end
  endfunction

  function automatic result_t reassemble(item_t it);
    result_t     r;
    int          d, cap, amt, n, keep;
    logic [31:0] diff;
    longint      soff, off;
    r = '0;
    d = int'(it.direction);
    cap = cap_now();
    amt = int'(it.amount);
    case (it.command)
      CMD_SEGMENT: begin
        if (!fail_closed) begin
          if (!base_set[d]) begin
            seq_base[d] = it.segment_seq;
            base_set[d] = 1'b1;
          end
          diff = it.segment_seq - seq_base[d];
          soff = longint'(signed'(diff));
          off  = soff + longint'(it.byte_index);
          if (off >= 0 && off < cap) begin
            // first copy of a byte wins
            if (!win_got[d][off]) begin
              win_data[d][off] = it.data_byte;
              win_got[d][off]  = 1'b1;
            end
            if (int'(off) + 1 > high_end[d]) high_end[d] = int'(off) + 1;
          end
          if (it.last_byte && off >= 0) begin
            if (soff < 0) soff = 0;
            if (soff >= cap) begin
              if (contig[d] < cap && soff - contig[d] > gap_reg) fail_closed = 1'b1;
            end else begin
              while (contig[d] < cap && win_got[d][contig[d]]) contig[d]++;
              feed_range(d, r);
              if (contig[d] < cap && high_end[d] - contig[d] > gap_reg)
                fail_closed = 1'b1;
            end
          end
        end
      end
      CMD_CONSUME: begin
        n = amt > contig[d] ? contig[d] : amt;
        if (n > 0) begin
          keep = high_end[d] > n ? high_end[d] - n : 0;
          for (int o = 0; o < keep; o++) begin
            if (o + n < WINDOW_BYTES) begin
              win_data[d][o] = win_data[d][o + n];
              win_got[d][o]  = win_got[d][o + n];
            end else begin
              win_got[d][o] = 1'b0;
            end
          end
          for (int o = keep; o < high_end[d] && o < WINDOW_BYTES; o++) win_got[d][o] = 1'b0;
          seq_base[d] = seq_base[d] + 32'(n);
          contig[d]   = contig[d] - n;
          high_end[d] = keep;
          scanned[d]  = scanned[d] > n ? scanned[d] - n : 0;
          budget[d]   = budget[d] > n ? budget[d] - n : 0;
        end
        if (it.reset_matcher) begin
          r.restart_matcher = 1'b1;
          scanned[d] = 0;
          budget[d]  = cap;
          if (contig[d] > 0) begin
            r.feed_valid = 1'b1;
            r.feed_end   = LEN_W'(contig[d]);
            scanned[d]   = contig[d];
          end
        end
      end
      CMD_LIMIT: begin
        budget[d] = amt > cap ? cap : amt;
        feed_range(d, r);
      end
      default: begin
        if (amt < cap && win_got[d][amt]) r.read_data = win_data[d][amt];
      end
    endcase
    r.status = fail_closed;
    r.contiguous_len = LEN_W'(contig[d]);
    return r;
  endfunction

  // result checker: each done compares against the oldest prediction
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("feed_valid", 32'(want.feed_valid), 32'(result.feed_valid));
        check_field("feed_start", 32'(want.feed_start), 32'(result.feed_start));
        check_field("feed_end", 32'(want.feed_end), 32'(result.feed_end));
        check_field("restart_matcher", 32'(want.restart_matcher),
                    32'(result.restart_matcher));
        check_field("contiguous_len", 32'(want.contiguous_len), 32'(result.contiguous_len));
        check_field("read_data", 32'(want.read_data), 32'(result.read_data));
      end
    end
  end

  // issue one item; start stays high into the next item unless a gap is due
  task automatic send_item(item_t it);
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(reassemble(it));
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // every few bursts run without gaps for a while
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic reg_idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_WINDOW_CAP) cap_reg = value & 32'h1FFF;
    else gap_reg = value & 32'hFFFF;
    @(posedge clk);
  endtask

  task automatic set_config(int cap, int gap);
    drain();
    cfg_write(REG_WINDOW_CAP, cap);
    cfg_write(REG_GAP_LIMIT, gap);
  endtask

  function automatic item_t noise_item(logic [1:0] cmd, logic d, int amt);
    item_t it;
    it.command       = cmd;
    it.direction     = d;
    it.segment_seq   = $urandom;
    it.byte_index    = 16'($urandom);
    it.data_byte     = 8'($urandom);
    it.last_byte     = 1'b0;
    it.amount        = 16'(amt);
    it.reset_matcher = 1'($urandom);
    return it;
  endfunction

  // one segment, bytes in order, relative to the current base
  task automatic send_segment(logic d, int rel, int len);
    item_t       it;
    logic [31:0] seq;
    seq = base_set[d] ? seq_base[d] + 32'(rel) : $urandom;
    for (int i = 0; i < len; i++) begin
      it = noise_item(CMD_SEGMENT, d, $urandom);
      it.segment_seq = seq;
      it.byte_index  = 16'(i);
      it.last_byte   = (i == len - 1);
      send_item(it);
    end
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic d, int amt, logic restart);
    item_t it;
    it = noise_item(cmd, d, amt);
    it.reset_matcher = restart;
    send_item(it);
  endtask

  task automatic test_directed();
    item_t it;
    // direction 1 starts just below the sequence wrap
    it = noise_item(CMD_SEGMENT, 1'b1, 0);
    for (int i = 0; i < 4; i++) begin
      it.segment_seq = 32'hFFFF_FFFE;
      it.byte_index  = 16'(i);
      it.data_byte   = (i == 0) ? 8'h00 : 8'hFF;
      it.last_byte   = (i == 3);
      send_item(it);
    end
    send_cmd(CMD_READ, 1'b1, 0, 1'b0);
    send_cmd(CMD_READ, 1'b1, 3, 1'b0);
    send_cmd(CMD_READ, 1'b1, 65535, 1'b0);
    send_cmd(CMD_LIMIT, 1'b1, 2, 1'b0);
    send_cmd(CMD_LIMIT, 1'b1, 65535, 1'b0);
    // direction 0: hole, then fill, then a retransmit whose copy must lose
    send_segment(1'b0, 0, 2);
    send_segment(1'b0, 5, 2);
    send_segment(1'b0, 2, 3);
    send_segment(1'b0, 0, 2);
    // segment wholly before the base
    send_segment(1'b0, -10, 3);
    send_cmd(CMD_CONSUME, 1'b0, 3, 1'b1);
    send_cmd(CMD_CONSUME, 1'b0, 65535, 1'b0);
    send_cmd(CMD_CONSUME, 1'b0, 0, 1'b1);
  endtask

  task automatic test_random(int cap, int gap, int count, bit ahead, bit pause);
    logic d;
    int   c, pick, last_sent;
    set_config(cap, gap);
    last_sent = items_sent;
    while (items_sent - last_sent < count) begin
      d = 1'($urandom);
      c = contig[d];
      pick = $urandom_range(0, 99);
      if (pause && items_sent - last_sent > count / 2) begin
        // hold off until the block has answered everything
        drain();
        pause = 1'b0;
      end
      if (pick < 55) begin
        if (ahead) send_segment(d, c + $urandom_range(0, 40) - 4, $urandom_range(1, 8));
        else send_segment(d, c - $urandom_range(0, 4), $urandom_range(1, 8));
      end else if (pick < 70) begin
        send_cmd(CMD_CONSUME, d, $urandom_range(0, c + 5), $urandom_range(0, 2) == 0);
      end else if (pick < 78) begin
        send_cmd(CMD_LIMIT, d, $urandom_range(0, 1) ? $urandom_range(0, c + 20) : $urandom,
                 1'b0);
      end else if (pick < 90) begin
        send_cmd(CMD_READ, d, $urandom_range(0, 3) ? $urandom_range(0, high_end[d] + 4)
                 : $urandom, 1'b0);
      end else begin
        // stray byte far from the window, never closing a segment
        send_item(noise_item(CMD_SEGMENT, d, $urandom));
      end
    end
  endtask

  task automatic test_fail_closed();
    set_config(64, 65535);
    send_cmd(CMD_CONSUME, 1'b0, 65535, 1'b0);
    // past the cap but within the allowed gap: nothing happens
    send_segment(1'b0, 100, 2);
    set_config(64, 10);
    // in-window hole wider than the gap limit trips the flag
    send_segment(1'b0, 30, 1);
    send_segment(1'b0, 0, 2);
    send_cmd(CMD_READ, 1'b0, 0, 1'b0);
    send_cmd(CMD_LIMIT, 1'b1, 65535, 1'b0);
    send_cmd(CMD_CONSUME, 1'b1, 1, 1'b1);
    for (int i = 0; i < 40; i++)
      send_item(noise_item(2'($urandom), 1'($urandom), $urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(4096, 2048, 250, 1'b1, 1'b1);
    test_random(64, 65535, 220, 1'b1, 1'b0);
    test_random(1, 100, 150, 1'b1, 1'b0);
    test_random(0, 300, 200, 1'b1, 1'b0);
    test_random(300, 0, 220, 1'b0, 1'b0);
    test_random(8191, 200, 220, 1'b1, 1'b0);
    test_fail_closed();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/tsrw_pkg.sv
design/tsrw_buf.sv
design/tsrw_regs.sv
design/tsrw_ctrl.sv
design/tcp_stream_reassembly_window.sv
dv/testbench.sv
